// ===== src/mlds_pkg.sv =====
`default_nettype none
package mlds_pkg;

    localparam int DIM       = 4;
    localparam int IW        = $clog2(DIM);
    localparam int AW        = $clog2(DIM * DIM);
    localparam int DW        = 32;
    localparam int CW        = 31;
    localparam int FRAC      = 16;
    localparam int DIV_STEPS = DW + FRAC;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_LOAD_MATRIX = 2'd0,
        OP_LOAD_VECTOR = 2'd1,
        OP_SOLVE       = 2'd2
    } op_t;

    typedef enum logic {
        REG_PIVOT_FLOOR    = 1'b0,
        REG_GROWTH_DIVISOR = 1'b1
    } reg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_FC_A, ST_FC_B, ST_FC_R, ST_FC_M1, ST_FC_N1, ST_FC_M2, ST_FC_S, ST_FC_W,
        ST_TH_R, ST_TH_C,
        ST_PV_D, ST_PV_W, ST_PV_M, ST_PV_N,
        ST_LD_R, ST_LD_D, ST_LD_W,
        ST_FW_A, ST_FW_B, ST_FW_R, ST_FW_M, ST_FW_S, ST_FW_W,
        ST_DG_R, ST_DG_D, ST_DG_W,
        ST_BW_A, ST_BW_B, ST_BW_R, ST_BW_M, ST_BW_S, ST_BW_W,
        ST_EM_R, ST_EM_L, ST_EM_H
    } state_t;

    function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(int'(r) * DIM + int'(c));
    endfunction

endpackage
`default_nettype wire

// ===== src/modified_ldl_solve_unit.sv =====
`default_nettype none
// channel | ports                                   | accepted when
// input   | s_operation s_row s_column s_value       | s_valid && s_ready
// result  | m_solution m_element_index m_last        | m_valid && m_ready
// config  | psel penable pwrite paddr pwdata prdata  | psel && penable && pwrite
// Load beats are accepted while idle; s_ready stays low while a solve runs.
// A solve does DIM*(DIM+1)/2 + DIM divides in the serial divider, plus
// (DIM^3-DIM)/6 factor multiply-subtracts and DIM*(DIM-1) substitution
// multiply-subtracts. Each result beat is held until m_ready; a stalled beat
// holds the sequencer. Reset clears control state only; stores need loading.
module modified_ldl_solve_unit import mlds_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_operation,
    input  wire logic [3:0]           s_row,
    input  wire logic [3:0]           s_column,
    input  wire logic signed [31:0]   s_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [31:0]        m_solution,
    output logic [3:0]                m_element_index,
    output logic                      m_last,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic signed [DW-1:0] mat_mem [DIM*DIM];
    logic signed [DW-1:0] fac_mem [DIM*DIM];
    logic signed [DW-1:0] pv_mem  [DIM];
    logic signed [DW-1:0] vec_mem [DIM];
    logic signed [DW-1:0] cw_mem  [DIM];

    state_t               state_reg, state_next;
    logic [IW-1:0]        i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [DW-1:0] acc_reg, acc_next, t_reg, t_next, op_a_reg, op_a_next;
    logic [DW-1:0]        piv_reg, piv_next;
    logic signed [63:0]   prod_reg;
    logic signed [DW-1:0] ma, mb;
    logic [CW-1:0]        pf_reg, gd_reg, alpha_eff, beta_eff;
    logic                 m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic signed [DW-1:0] m_sol_reg, m_sol_next;
    logic [IW-1:0]        m_idx_reg, m_idx_next;

    logic signed [DW-1:0] mat_rd, f_rd0, f_rd1, pv_rd, v_rd0, v_rd1, cw_rd;
    logic [AW-1:0]        mat_raddr, f_raddr0, f_raddr1;
    logic [IW-1:0]        pv_raddr, cw_raddr;
    logic                 mat_we, fac_we, pv_we, vec_we, cw_we;
    logic [AW-1:0]        mat_waddr;
    logic [IW-1:0]        vec_waddr;
    logic signed [DW-1:0] vec_wdata;

    logic                 div_start, div_done;
    logic signed [DW-1:0] div_num, div_quo;
    logic [CW-1:0]        div_den;
    logic                 cfg_we;

    function automatic logic signed [DW-1:0] q_round(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd32768) >>> FRAC;
        if (t > 64'sd2147483647)
            return {1'b0, {(DW-1){1'b1}}};
        else if (t < -64'sd2147483648)
            return {1'b1, {(DW-1){1'b0}}};
        else
            return DW'(t);
    endfunction

    function automatic logic signed [DW-1:0] q_sub(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
        logic signed [DW:0] d;
        d = {a[DW-1], a} - {b[DW-1], b};
        if (d[DW] != d[DW-1])
            return d[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            return d[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] q_abs(input logic signed [DW-1:0] a);
        if (a == {1'b1, {(DW-1){1'b0}}})
            return {1'b0, {(DW-1){1'b1}}};
        else
            return a[DW-1] ? DW'(-a) : DW'(a);
    endfunction

    // configuration
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign alpha_eff = (pf_reg == '0) ? CW'(1) : pf_reg;
    assign beta_eff  = (gd_reg == '0) ? CW'(1) : gd_reg;
    assign prdata    = (reg_idx_t'(paddr[2]) == REG_PIVOT_FLOOR) ? {1'b0, pf_reg}
                                                                  : {1'b0, gd_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pf_reg <= CW'(32768);
            gd_reg <= CW'(131072);
        end else if (cfg_we) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_PIVOT_FLOOR:    pf_reg <= pwdata[CW-1:0];
                REG_GROWTH_DIVISOR: gd_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // stores
    assign mat_raddr = maddr(i_reg, j_reg);
    assign f_raddr1  = maddr(i_reg, k_reg);
    assign pv_raddr  = (state_reg == ST_DG_R) ? i_reg : k_reg;
    assign cw_raddr  = (state_reg == ST_TH_R || state_reg == ST_LD_R) ? i_reg : j_reg;

    always_comb begin
        unique case (state_reg)
            ST_FW_R: f_raddr0 = maddr(i_reg, j_reg);
            ST_BW_R: f_raddr0 = maddr(j_reg, i_reg);
            default: f_raddr0 = maddr(j_reg, k_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mat_we)
            mat_mem[mat_waddr] <= s_value;
        mat_rd <= mat_mem[mat_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fac_we)
            fac_mem[maddr(i_reg, j_reg)] <= div_quo;
        f_rd0 <= fac_mem[f_raddr0];
        f_rd1 <= fac_mem[f_raddr1];
    end

    always_ff @(posedge aclk) begin
        if (pv_we)
            pv_mem[j_reg] <= piv_next;
        pv_rd <= pv_mem[pv_raddr];
    end

    always_ff @(posedge aclk) begin
        if (vec_we)
            vec_mem[vec_waddr] <= vec_wdata;
        v_rd0 <= vec_mem[i_reg];
        v_rd1 <= vec_mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (cw_we)
            cw_mem[i_reg] <= acc_reg;
        cw_rd <= cw_mem[cw_raddr];
    end

    // shared multiplier
    always_comb begin
        unique case (state_reg)
            ST_FC_M2: begin ma = op_a_reg; mb = pv_rd; end
            ST_PV_M:  begin ma = op_a_reg; mb = op_a_reg; end
            ST_FW_M, ST_BW_M:
                      begin ma = v_rd1; mb = f_rd0; end
            default:  begin ma = f_rd0; mb = f_rd1; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
    end

    mlds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        t_reg     <= t_next;
        op_a_reg  <= op_a_next;
        piv_reg   <= piv_next;
        m_sol_reg <= m_sol_next;
        m_idx_reg <= m_idx_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        logic [DW-1:0] sq_v;
        logic [DW-1:0] abs_v;
        logic [DW-1:0] piv_v;
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        t_next       = t_reg;
        op_a_next    = op_a_reg;
        piv_next     = piv_reg;
        m_valid_next = m_valid_reg;
        m_sol_next   = m_sol_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;
        mat_we       = 1'b0;
        mat_waddr    = maddr(s_row[IW-1:0], s_column[IW-1:0]);
        fac_we       = 1'b0;
        pv_we        = 1'b0;
        cw_we        = 1'b0;
        vec_we       = 1'b0;
        vec_waddr    = i_reg;
        vec_wdata    = acc_reg;
        div_start    = 1'b0;
        div_num      = cw_rd;
        div_den      = piv_reg[CW-1:0];
        sq_v         = DW'(q_round(prod_reg));
        abs_v        = q_abs(cw_rd);
        piv_v        = (sq_v < {1'b0, alpha_eff}) ? {1'b0, alpha_eff} : sq_v;
        if (abs_v > piv_v)
            piv_v = abs_v;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_operation)
                        OP_LOAD_MATRIX: begin
                            mat_we = (int'(s_row) < DIM) && (int'(s_column) < DIM);
                        end
                        OP_LOAD_VECTOR: begin
                            vec_we    = int'(s_row) < DIM;
                            vec_waddr = s_row[IW-1:0];
                            vec_wdata = s_value;
                        end
                        OP_SOLVE: begin
                            i_next     = '0;
                            j_next     = '0;
                            state_next = ST_FC_A;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FC_A: state_next = ST_FC_B;
            ST_FC_B: begin
                acc_next = mat_rd;
                k_next   = '0;
                state_next = (j_reg == '0) ? ST_FC_W : ST_FC_R;
            end
            ST_FC_R:  state_next = ST_FC_M1;
            ST_FC_M1: state_next = ST_FC_N1;
            ST_FC_N1: begin
                op_a_next  = q_round(prod_reg);
                state_next = ST_FC_M2;
            end
            ST_FC_M2: state_next = ST_FC_S;
            ST_FC_S: begin
                acc_next = q_sub(acc_reg, q_round(prod_reg));
                if (k_reg == IW'(j_reg - 1'b1)) begin
                    state_next = ST_FC_W;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_FC_R;
                end
            end
            ST_FC_W: begin
                cw_we = 1'b1;
                if (i_reg == IW'(DIM - 1)) begin
                    if (j_reg == IW'(DIM - 1)) begin
                        t_next     = '0;
                        state_next = ST_PV_D;
                    end else begin
                        i_next     = j_reg + 1'b1;
                        state_next = ST_TH_R;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_FC_A;
                end
            end
            ST_TH_R: state_next = ST_TH_C;
            ST_TH_C: begin
                if (i_reg == IW'(j_reg + 1'b1) || cw_rd > t_reg)
                    t_next = cw_rd;
                if (i_reg == IW'(DIM - 1)) begin
                    state_next = ST_PV_D;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_TH_R;
                end
            end
            ST_PV_D: begin
                div_start  = 1'b1;
                div_num    = t_reg;
                div_den    = beta_eff;
                state_next = ST_PV_W;
            end
            ST_PV_W: begin
                if (div_done) begin
                    op_a_next  = div_quo;
                    state_next = ST_PV_M;
                end
            end
            ST_PV_M: state_next = ST_PV_N;
            ST_PV_N: begin
                piv_next = piv_v;
                pv_we    = 1'b1;
                if (j_reg == IW'(DIM - 1)) begin
                    i_next     = IW'(1);
                    state_next = ST_FW_A;
                end else begin
                    i_next     = j_reg + 1'b1;
                    state_next = ST_LD_R;
                end
            end
            ST_LD_R: state_next = ST_LD_D;
            ST_LD_D: begin
                div_start  = 1'b1;
                state_next = ST_LD_W;
            end
            ST_LD_W: begin
                if (div_done) begin
                    fac_we = 1'b1;
                    if (i_reg == IW'(DIM - 1)) begin
                        j_next     = j_reg + 1'b1;
                        i_next     = j_reg + 1'b1;
                        state_next = ST_FC_A;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_LD_R;
                    end
                end
            end
            ST_FW_A: state_next = ST_FW_B;
            ST_FW_B: begin
                acc_next   = v_rd0;
                j_next     = '0;
                state_next = ST_FW_R;
            end
            ST_FW_R: state_next = ST_FW_M;
            ST_FW_M: state_next = ST_FW_S;
            ST_FW_S: begin
                acc_next = q_sub(acc_reg, q_round(prod_reg));
                if (j_reg == IW'(i_reg - 1'b1)) begin
                    state_next = ST_FW_W;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_FW_R;
                end
            end
            ST_FW_W: begin
                vec_we = 1'b1;
                if (i_reg == IW'(DIM - 1)) begin
                    i_next     = '0;
                    state_next = ST_DG_R;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_FW_A;
                end
            end
            ST_DG_R: state_next = ST_DG_D;
            ST_DG_D: begin
                div_start  = 1'b1;
                div_num    = v_rd0;
                div_den    = pv_rd[CW-1:0];
                state_next = ST_DG_W;
            end
            ST_DG_W: begin
                if (div_done) begin
                    vec_we    = 1'b1;
                    vec_wdata = div_quo;
                    if (i_reg == IW'(DIM - 1)) begin
                        i_next     = IW'(DIM - 2);
                        state_next = ST_BW_A;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_DG_R;
                    end
                end
            end
            ST_BW_A: state_next = ST_BW_B;
            ST_BW_B: begin
                acc_next   = v_rd0;
                j_next     = IW'(DIM - 1);
                state_next = ST_BW_R;
            end
            ST_BW_R: state_next = ST_BW_M;
            ST_BW_M: state_next = ST_BW_S;
            ST_BW_S: begin
                acc_next = q_sub(acc_reg, q_round(prod_reg));
                if (j_reg == IW'(i_reg + 1'b1)) begin
                    state_next = ST_BW_W;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = ST_BW_R;
                end
            end
            ST_BW_W: begin
                vec_we = 1'b1;
                if (i_reg == '0) begin
                    state_next = ST_EM_R;
                end else begin
                    i_next     = i_reg - 1'b1;
                    state_next = ST_BW_A;
                end
            end
            ST_EM_R: state_next = ST_EM_L;
            ST_EM_L: begin
                m_sol_next   = v_rd0;
                m_idx_next   = i_reg;
                m_last_next  = i_reg == IW'(DIM - 1);
                m_valid_next = 1'b1;
                state_next   = ST_EM_H;
            end
            ST_EM_H: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_EM_R;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready         = state_reg == ST_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_solution      = m_sol_reg;
    assign m_element_index = 4'(m_idx_reg);
    assign m_last          = m_last_reg;

    a_valid_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_EM_H)
        else $error("result valid outside emit hold");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while result pending");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> state_reg == ST_IDLE)
        else $error("sequencer not idle after last beat");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> !m_valid)
        else $error("result beat repeated");

endmodule
`default_nettype wire

// ===== src/mlds_div.sv =====
`default_nettype none
module mlds_div import mlds_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [DW-1:0] num,
    input  wire logic [CW-1:0]        den,
    output logic                      done,
    output logic signed [DW-1:0]      quo
);

    logic [DIV_STEPS-1:0] dvd_reg;
    logic [DW-1:0]        rem_reg;
    logic [CW-1:0]        den_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DW-1:0]        trial;
    logic                 ge;
    logic [DW-1:0]        num_abs;

    assign num_abs = num[DW-1] ? DW'(-num) : DW'(num);
    assign trial   = {rem_reg[DW-2:0], dvd_reg[DIV_STEPS-1]};
    assign ge      = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg <= {num_abs, {FRAC{1'b0}}};
                rem_reg <= '0;
                den_reg <= den;
                neg_reg <= num[DW-1];
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                rem_reg <= ge ? trial - {1'b0, den_reg} : trial;
                dvd_reg <= {dvd_reg[DIV_STEPS-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            if (dvd_reg > DIV_STEPS'(64'h8000_0000))
                quo = {1'b1, {(DW-1){1'b0}}};
            else
                quo = DW'(-dvd_reg);
        end else begin
            if (dvd_reg > DIV_STEPS'(64'h7FFF_FFFF))
                quo = {1'b0, {(DW-1){1'b1}}};
            else
                quo = DW'(dvd_reg);
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire
